@@ rtl/mlti_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the multilinear table interpolator.
// Used by multilinear_table_interpolator; depends on nothing.

package mlti_pkg;

    // Two axes, last axis varies fastest in the table
    localparam int DIMS     = 2;
    localparam int MAX_ROWS = 64;
    localparam int IDX_W    = 6;    // index into one axis, 0 .. MAX_ROWS-1
    localparam int ROWS_W   = 7;
    localparam int VAL_W    = 51;   // intermediate values, saturate at +-(2^46-1)
    localparam int ADDR_W   = 16;   // computed table address

    localparam logic signed [VAL_W-1:0] VLIM = 51'sd70368744177663;
    localparam logic signed [VAL_W-1:0] Q_MAX = 51'sd2147483647;
    localparam logic signed [VAL_W-1:0] Q_MIN = -51'sd2147483648;

    // configuration register indexes
    localparam logic [2:0] CFG_START_0    = 3'd0;
    localparam logic [2:0] CFG_START_1    = 3'd1;
    localparam logic [2:0] CFG_INV_STEP_0 = 3'd2;
    localparam logic [2:0] CFG_INV_STEP_1 = 3'd3;
    localparam logic [2:0] CFG_ROWS_0     = 3'd4;
    localparam logic [2:0] CFG_ROWS_1     = 3'd5;

    // command codes (tuser)
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // bounds codes, 2-bit signed
    localparam logic [1:0] BND_INSIDE  = 2'b00;
    localparam logic [1:0] BND_ABOVE   = 2'b01;
    localparam logic [1:0] BND_SHIFTED = 2'b10;
    localparam logic [1:0] BND_BELOW   = 2'b11;

    typedef logic signed [VAL_W-1:0] val_t;

    // per-axis setup result
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [16:0]      frac;   // 0 .. 65536
        logic [1:0]       k;      // derivative order, 0..2
        logic [2:0]       total;  // grid points used, 1..4
        logic             zero;   // rows not above order: axis yields 0
        logic [1:0]       bnd;
    } dim_t;

endpackage

`default_nettype wire

@@ rtl/mlti_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mlti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/multilinear_table_interpolator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the two-axis table interpolator: sequencer, config registers,
// one shared 32x32 multiplier. Depends on mlti_pkg and mlti_ram.
//
// Usage:
//  s_axis carries one word per command. tuser = command: write stores
//  entry_value at entry_address (no result); evaluate computes an
//  interpolated value or finite-difference derivative per axis and returns
//  one m_axis word with the value, the per-axis bounds codes and a
//  saturation flag.
//  The cfg port writes start, inv_step and rows registers at any edge with
//  cfg_wr_en high; do so only while no evaluate is in flight.
//  An evaluate walks a fixed sequence through the single multiplier (two
//  passes per product) and the single RAM read port (read issue, then
//  capture, per entry): setup of each axis, the row base, then per row the
//  reads of its points plus a blend, and finally a blend over axis 0. Each
//  blend scales its two endpoint terms by inv_step once per derivative
//  order and then weights them by 1 - frac and frac. s_axis_tready is low
//  for the whole evaluate.
//  A finished result sits in the output register until taken; write words
//  are still accepted meanwhile, the next evaluate stalls at its end.
//  Reset returns config to start 0, inv_step 1.0, rows 2; table contents
//  are not cleared and must be written before they are read.

module multilinear_table_interpolator #(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // command stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_address[11:0], entry_value[43:12], coord_0[75:44], coord_1[107:76],
    // deriv_0[109:108], deriv_1[111:110]
    input  wire logic [111:0] s_axis_tdata,
    // command[0]
    input  wire logic         s_axis_tuser,
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_value[31:0], bounds_0[33:32], bounds_1[35:34], saturated[36], zero pad
    output logic [39:0]       m_axis_tdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SU_MUL, ST_SU_POST, ST_BASE, ST_BASE_POST, ST_ROW, ST_RD, ST_RDW,
        ST_CB_D, ST_CB_INV, ST_CB_INVP, ST_BL0, ST_BL0P, ST_BL1, ST_BL1P,
        ST_MUL0, ST_MUL1, ST_FIN
    } state_t;

    // config registers
    logic [31:0] start0_reg, start1_reg, inv0_reg, inv1_reg;
    logic [mlti_pkg::ROWS_W-1:0] rows0_reg, rows1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start0_reg <= '0;
            start1_reg <= '0;
            inv0_reg   <= 32'd65536;
            inv1_reg   <= 32'd65536;
            rows0_reg  <= 7'd2;
            rows1_reg  <= 7'd2;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mlti_pkg::CFG_START_0:    start0_reg <= cfg_data;
                mlti_pkg::CFG_START_1:    start1_reg <= cfg_data;
                mlti_pkg::CFG_INV_STEP_0: inv0_reg   <= cfg_data;
                mlti_pkg::CFG_INV_STEP_1: inv1_reg   <= cfg_data;
                mlti_pkg::CFG_ROWS_0:     rows0_reg  <= cfg_data[6:0];
                mlti_pkg::CFG_ROWS_1:     rows1_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    state_t                    state_reg, ret_reg;
    logic                      sd_reg;      // axis under setup
    logic                      lv_reg;      // 1: blending axis 1, 0: axis 0
    logic                      j_reg;       // which of the two blend endpoints
    logic [1:0]                pass_reg;    // remaining inv_step products
    logic [1:0]                c0_reg, c1_reg;
    logic [mlti_pkg::ADDR_W-1:0] row_base_reg;
    logic                      in_range_reg;
    logic                      su_neg_reg, su_invnz_reg;
    logic [31:0]               coord0_reg, coord1_reg;
    mlti_pkg::dim_t            dim0_reg, dim1_reg;
    mlti_pkg::val_t            f_reg [4];
    mlti_pkg::val_t            g_reg [4];
    mlti_pkg::val_t            v_reg [2];
    mlti_pkg::val_t            cur_reg;
    logic signed [63:0]        acc_reg;
    logic [31:0]               res_reg;
    logic                      sat_reg;
    logic [63:0]               mul_a_reg;
    logic [31:0]               mul_b_reg;
    logic                      mul_neg_reg;
    logic [95:0]               prod_reg;
    logic                      out_valid_reg;
    logic [39:0]               out_data_reg;

    // input fields
    logic        s_fire;
    logic        cmd;
    logic [11:0] in_addr;
    logic [31:0] in_value;
    logic [1:0]  in_k0, in_k1;
    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign cmd      = s_axis_tuser;
    assign in_addr  = s_axis_tdata[11:0];
    assign in_value = s_axis_tdata[43:12];
    assign in_k0    = (s_axis_tdata[109:108] == 2'd3) ? 2'd2 : s_axis_tdata[109:108];
    assign in_k1    = (s_axis_tdata[111:110] == 2'd3) ? 2'd2 : s_axis_tdata[111:110];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // clamped row counts
    logic [mlti_pkg::ROWS_W-1:0] rows0_c, rows1_c;
    assign rows0_c = (rows0_reg > 7'(mlti_pkg::MAX_ROWS)) ? 7'(mlti_pkg::MAX_ROWS) : rows0_reg;
    assign rows1_c = (rows1_reg > 7'(mlti_pkg::MAX_ROWS)) ? 7'(mlti_pkg::MAX_ROWS) : rows1_reg;

    // shared multiplier: 64-bit operand taken in two 32-bit halves
    logic [31:0] mul_x;
    logic [63:0] mul_p;
    assign mul_x = (state_reg == ST_MUL1) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_p = mul_x * mul_b_reg;

    // axis setup
    logic [31:0]                 coord_s, start_s, inv_s;
    logic [mlti_pkg::ROWS_W-1:0] rows_s;
    mlti_pkg::dim_t              dim_s, dim_new;
    logic signed [32:0]          diff_s;
    logic [31:0]                 mag_s;
    logic signed [49:0]          real_s;
    logic                        below_s, rk1_s;
    logic [33:0]                 idx_w;
    logic [34:0]                 idx_end;
    logic [2:0]                  total_s;

    assign coord_s = sd_reg ? coord1_reg : coord0_reg;
    assign start_s = sd_reg ? start1_reg : start0_reg;
    assign inv_s   = sd_reg ? inv1_reg : inv0_reg;
    assign rows_s  = sd_reg ? rows1_c : rows0_c;
    assign dim_s   = sd_reg ? dim1_reg : dim0_reg;
    assign diff_s  = $signed({coord_s[31], coord_s}) - $signed({start_s[31], start_s});
    assign mag_s   = diff_s[32] ? 32'd0 : diff_s[31:0];
    // position minus half a step per derivative order
    assign real_s  = $signed({2'b00, prod_reg[63:16]}) - $signed({33'd0, dim_s.k, 15'd0});
    assign below_s = (su_neg_reg && su_invnz_reg) || real_s[49];
    assign idx_w   = real_s[49:16];
    assign rk1_s   = (rows_s == ({5'd0, dim_s.k} + 7'd1));
    assign total_s = rk1_s ? ({1'b0, dim_s.k} + 3'd1) : ({1'b0, dim_s.k} + 3'd2);
    assign idx_end = {1'b0, idx_w} + {32'd0, total_s};

    always_comb
    begin
        dim_new       = dim_s;
        dim_new.total = total_s;
        dim_new.zero  = (rows_s <= {5'd0, dim_s.k});
        if (below_s)
        begin
            dim_new.idx  = '0;
            dim_new.frac = '0;
            if (su_neg_reg)
                dim_new.bnd = mlti_pkg::BND_BELOW;
            else if (rows_s > 7'd3)
                dim_new.bnd = mlti_pkg::BND_SHIFTED;
            else
                dim_new.bnd = mlti_pkg::BND_INSIDE;
        end
        else if (idx_end > {28'd0, rows_s})
        begin
            dim_new.idx  = 6'(rows_s - 7'd2 - {5'd0, dim_s.k});
            dim_new.frac = 17'd65536;
            dim_new.bnd  = mlti_pkg::BND_ABOVE;
        end
        else
        begin
            dim_new.idx  = idx_w[5:0];
            dim_new.frac = {1'b0, real_s[15:0]};
            dim_new.bnd  = mlti_pkg::BND_INSIDE;
        end
        if (rk1_s)
        begin
            dim_new.idx  = '0;
            dim_new.frac = '0;
        end
    end

    // blend operands of the current level
    mlti_pkg::val_t src0, src1, src2, src3, dd0, dd1, dd_j;
    logic [1:0]     k_l;
    logic [16:0]    frac_l;
    logic [31:0]    inv_l;
    assign src0   = lv_reg ? f_reg[0] : g_reg[0];
    assign src1   = lv_reg ? f_reg[1] : g_reg[1];
    assign src2   = lv_reg ? f_reg[2] : g_reg[2];
    assign src3   = lv_reg ? f_reg[3] : g_reg[3];
    assign k_l    = lv_reg ? dim1_reg.k : dim0_reg.k;
    assign frac_l = lv_reg ? dim1_reg.frac : dim0_reg.frac;
    assign inv_l  = lv_reg ? inv1_reg : inv0_reg;

    always_comb
    begin
        unique case (k_l)
            2'd0:
            begin
                dd0 = src0;
                dd1 = src1;
            end
            2'd1:
            begin
                dd0 = src1 - src0;
                dd1 = src2 - src1;
            end
            default:
            begin
                dd0 = src0 + src2 - (src1 <<< 1);
                dd1 = src1 + src3 - (src2 <<< 1);
            end
        endcase
    end
    assign dd_j = j_reg ? dd1 : dd0;

    function automatic logic [63:0] mag64(input mlti_pkg::val_t x);
        logic [mlti_pkg::VAL_W-1:0] m;
        m = x[mlti_pkg::VAL_W-1] ? 51'(-x) : 51'(x);
        return {13'd0, m};
    endfunction

    // product post-processing
    logic           inv_sat;
    mlti_pkg::val_t inv_mag;
    logic signed [63:0] p_signed, sum_s, sum_adj;
    mlti_pkg::val_t q_s;
    assign inv_sat  = |prod_reg[95:62];
    assign inv_mag  = inv_sat ? mlti_pkg::VLIM : $signed({4'd0, prod_reg[62:16]});
    assign p_signed = mul_neg_reg ? -$signed({1'b0, prod_reg[62:0]})
                                  : $signed({1'b0, prod_reg[62:0]});
    assign sum_s    = acc_reg + p_signed;
    // divide by 65536 toward zero
    assign sum_adj  = sum_s + (sum_s[63] ? 64'sd65535 : 64'sd0);
    assign q_s      = $signed({{3{sum_adj[63]}}, sum_adj[63:16]});

    // table
    logic [mlti_pkg::ADDR_W-1:0] wr_addr16, rd_addr16;
    logic                        wr_en;
    logic [31:0]                 rd_data;
    assign wr_addr16 = {4'd0, in_addr};
    assign wr_en     = s_fire && (cmd == mlti_pkg::CMD_WRITE) && ({1'b0, wr_addr16} < DEPTH_L);
    assign rd_addr16 = row_base_reg + {10'd0, dim1_reg.idx} + {14'd0, c1_reg};

    mlti_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr16[AW-1:0]),
        .wr_data (in_value),
        .rd_en   (state_reg == ST_RD),
        .rd_addr (rd_addr16[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            sd_reg        <= 1'b0;
            lv_reg        <= 1'b0;
            j_reg         <= 1'b0;
            pass_reg      <= '0;
            c0_reg        <= '0;
            c1_reg        <= '0;
            row_base_reg  <= '0;
            in_range_reg  <= 1'b0;
            su_neg_reg    <= 1'b0;
            su_invnz_reg  <= 1'b0;
            coord0_reg    <= '0;
            coord1_reg    <= '0;
            dim0_reg      <= '0;
            dim1_reg      <= '0;
            for (int i = 0; i < 4; i++)
            begin
                f_reg[i] <= '0;
                g_reg[i] <= '0;
            end
            v_reg[0]      <= '0;
            v_reg[1]      <= '0;
            cur_reg       <= '0;
            acc_reg       <= '0;
            res_reg       <= '0;
            sat_reg       <= 1'b0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_neg_reg   <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // ST_FIN owns the valid flag in its own cycle
            if (out_valid_reg && m_axis_tready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire && (cmd == mlti_pkg::CMD_EVAL))
                    begin
                        coord0_reg <= s_axis_tdata[75:44];
                        coord1_reg <= s_axis_tdata[107:76];
                        dim0_reg.k <= in_k0;
                        dim1_reg.k <= in_k1;
                        sat_reg    <= 1'b0;
                        sd_reg     <= 1'b0;
                        for (int i = 0; i < 4; i++)
                        begin
                            g_reg[i] <= '0;
                        end
                        state_reg  <= ST_SU_MUL;
                    end
                end

                ST_SU_MUL:
                begin
                    su_neg_reg   <= diff_s[32];
                    su_invnz_reg <= (inv_s != 32'd0);
                    mul_a_reg    <= {32'd0, mag_s};
                    mul_b_reg    <= inv_s;
                    mul_neg_reg  <= 1'b0;
                    ret_reg      <= ST_SU_POST;
                    state_reg    <= ST_MUL0;
                end

                ST_SU_POST:
                begin
                    if (sd_reg)
                    begin
                        dim1_reg <= dim_new;
                        if (dim0_reg.zero || dim_new.zero)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_BASE;
                        end
                    end
                    else
                    begin
                        dim0_reg  <= dim_new;
                        sd_reg    <= 1'b1;
                        state_reg <= ST_SU_MUL;
                    end
                end

                ST_BASE:
                begin
                    mul_a_reg   <= {58'd0, dim0_reg.idx};
                    mul_b_reg   <= {25'd0, rows1_c};
                    mul_neg_reg <= 1'b0;
                    c0_reg      <= '0;
                    ret_reg     <= ST_BASE_POST;
                    state_reg   <= ST_MUL0;
                end

                ST_BASE_POST:
                begin
                    row_base_reg <= prod_reg[15:0];
                    state_reg    <= ST_ROW;
                end

                ST_ROW:
                begin
                    c1_reg <= '0;
                    for (int i = 0; i < 4; i++)
                    begin
                        f_reg[i] <= '0;
                    end
                    state_reg <= ST_RD;
                end

                ST_RD:
                begin
                    in_range_reg <= ({1'b0, rd_addr16} < DEPTH_L);
                    state_reg    <= ST_RDW;
                end

                ST_RDW:
                begin
                    f_reg[c1_reg] <= in_range_reg ? 51'($signed(rd_data)) : '0;
                    if (({1'b0, c1_reg} + 3'd1) == dim1_reg.total)
                    begin
                        lv_reg    <= 1'b1;
                        j_reg     <= 1'b0;
                        state_reg <= ST_CB_D;
                    end
                    else
                    begin
                        c1_reg    <= c1_reg + 2'd1;
                        state_reg <= ST_RD;
                    end
                end

                ST_CB_D:
                begin
                    cur_reg   <= dd_j;
                    pass_reg  <= k_l;
                    state_reg <= ST_CB_INV;
                end

                ST_CB_INV:
                begin
                    if (pass_reg == 2'd0)
                    begin
                        v_reg[j_reg] <= cur_reg;
                        if (j_reg)
                        begin
                            state_reg <= ST_BL0;
                        end
                        else
                        begin
                            j_reg     <= 1'b1;
                            state_reg <= ST_CB_D;
                        end
                    end
                    else
                    begin
                        mul_a_reg   <= mag64(cur_reg);
                        mul_b_reg   <= inv_l;
                        mul_neg_reg <= cur_reg[mlti_pkg::VAL_W-1];
                        ret_reg     <= ST_CB_INVP;
                        state_reg   <= ST_MUL0;
                    end
                end

                ST_CB_INVP:
                begin
                    if (inv_sat && (mul_b_reg != 32'd0))
                    begin
                        sat_reg <= 1'b1;
                    end
                    cur_reg   <= mul_neg_reg ? -inv_mag : inv_mag;
                    pass_reg  <= pass_reg - 2'd1;
                    state_reg <= ST_CB_INV;
                end

                ST_BL0:
                begin
                    mul_a_reg   <= mag64(v_reg[0]);
                    mul_b_reg   <= {15'd0, 17'd65536 - frac_l};
                    mul_neg_reg <= v_reg[0][mlti_pkg::VAL_W-1];
                    ret_reg     <= ST_BL0P;
                    state_reg   <= ST_MUL0;
                end

                ST_BL0P:
                begin
                    acc_reg   <= p_signed;
                    state_reg <= ST_BL1;
                end

                ST_BL1:
                begin
                    mul_a_reg   <= mag64(v_reg[1]);
                    mul_b_reg   <= {15'd0, frac_l};
                    mul_neg_reg <= v_reg[1][mlti_pkg::VAL_W-1];
                    ret_reg     <= ST_BL1P;
                    state_reg   <= ST_MUL0;
                end

                ST_BL1P:
                begin
                    if (lv_reg)
                    begin
                        g_reg[c0_reg] <= q_s;
                        if (({1'b0, c0_reg} + 3'd1) == dim0_reg.total)
                        begin
                            lv_reg    <= 1'b0;
                            j_reg     <= 1'b0;
                            state_reg <= ST_CB_D;
                        end
                        else
                        begin
                            c0_reg       <= c0_reg + 2'd1;
                            row_base_reg <= row_base_reg + {9'd0, rows1_c};
                            state_reg    <= ST_ROW;
                        end
                    end
                    else
                    begin
                        if (q_s > mlti_pkg::Q_MAX)
                        begin
                            res_reg <= 32'h7FFF_FFFF;
                            sat_reg <= 1'b1;
                        end
                        else if (q_s < mlti_pkg::Q_MIN)
                        begin
                            res_reg <= 32'h8000_0000;
                            sat_reg <= 1'b1;
                        end
                        else
                        begin
                            res_reg <= q_s[31:0];
                        end
                        state_reg <= ST_FIN;
                    end
                end

                ST_MUL0:
                begin
                    prod_reg  <= {32'd0, mul_p};
                    state_reg <= ST_MUL1;
                end

                ST_MUL1:
                begin
                    prod_reg  <= prod_reg + {mul_p, 32'd0};
                    state_reg <= ret_reg;
                end

                ST_FIN:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, sat_reg,
                                          (dim0_reg.zero || dim1_reg.zero)
                                              ? mlti_pkg::BND_INSIDE : dim1_reg.bnd,
                                          dim0_reg.zero ? mlti_pkg::BND_INSIDE : dim0_reg.bnd,
                                          res_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // a table write finishes in the cycle it is taken
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (cmd == mlti_pkg::CMD_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("write word left the sequencer busy");

    // an evaluate always starts with axis setup
    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (cmd == mlti_pkg::CMD_EVAL)) |=> (state_reg == ST_SU_MUL))
        else $error("evaluate did not enter setup");

    // read data is captured only right after the read was issued
    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDW) |-> ($past(state_reg) == ST_RD))
        else $error("table data captured without a read");

    // the second multiply pass always follows the first
    a_mul_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL0) |=> (state_reg == ST_MUL1))
        else $error("multiplier pass sequence broken");

endmodule

`default_nettype wire
